@@ hw/rtl/mfr_pkg.sv @@
package mfr_pkg;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam int unsigned FRAME_OVERHEAD = 12;
  localparam int unsigned ADDR_BYTES = 6;
  localparam int unsigned ADDR_W = 8 * ADDR_BYTES;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ADDR = 2'd1,
    ST_CSUM = 2'd2,
    ST_SYNC = 2'd3
  } status_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [7:0]  control_code;
    logic [7:0]  data_length;
  } result_t;

endpackage

@@ hw/rtl/mfr_parser.sv @@
module mfr_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_en,
  input  logic [7:0]                 rx_byte,
  input  logic [mfr_pkg::ADDR_W-1:0] meter_address,
  output mfr_pkg::result_t           result
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_SYNC,
    PH_CTRL,
    PH_LEN,
    PH_DATA,
    PH_CSUM,
    PH_END
  } phase_t;

  localparam logic [8:0] DATA_END_OFS = 9'(mfr_pkg::FRAME_OVERHEAD - 2);

  phase_t     phase_r, phase_nxt;
  logic [8:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       addr_bad_r, addr_bad_nxt;
  logic       csum_bad_r, csum_bad_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic [7:0] len_r, len_nxt;
  logic [2:0] addr_idx;
  logic [7:0] addr_want;
  logic [8:0] pos_inc;

  assign addr_idx = 3'(pos_r - 9'd1);
  assign pos_inc  = pos_r + 9'd1;

  always_comb begin
    unique case (addr_idx)
      3'd0:    addr_want = meter_address[7:0];
      3'd1:    addr_want = meter_address[15:8];
      3'd2:    addr_want = meter_address[23:16];
      3'd3:    addr_want = meter_address[31:24];
      3'd4:    addr_want = meter_address[39:32];
      3'd5:    addr_want = meter_address[47:40];
      default: addr_want = 8'd0;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    addr_bad_nxt = addr_bad_r;
    csum_bad_nxt = csum_bad_r;
    ctrl_nxt     = ctrl_r;
    len_nxt      = len_r;
    result       = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == mfr_pkg::START_BYTE) begin
          sum_nxt      = rx_byte;
          pos_nxt      = 9'd1;
          addr_bad_nxt = 1'b0;
          csum_bad_nxt = 1'b0;
          phase_nxt    = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (rx_byte != addr_want) begin
          addr_bad_nxt = 1'b1;
        end
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_inc;
        if (pos_inc >= 9'(mfr_pkg::ADDR_BYTES + 1)) begin
          phase_nxt = PH_SYNC;
        end
      end
      PH_SYNC: begin
        if (rx_byte == mfr_pkg::START_BYTE) begin
          sum_nxt   = sum_r + rx_byte;
          pos_nxt   = 9'd8;
          phase_nxt = PH_CTRL;
        end else begin
          result.valid  = 1'b1;
          result.kind   = mfr_pkg::KIND_END;
          result.status = mfr_pkg::ST_SYNC;
          pos_nxt       = 9'd0;
          phase_nxt     = PH_HUNT;
        end
      end
      PH_CTRL: begin
        ctrl_nxt  = rx_byte;
        sum_nxt   = sum_r + rx_byte;
        pos_nxt   = 9'd9;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = rx_byte;
        sum_nxt   = sum_r + rx_byte;
        pos_nxt   = 9'd10;
        phase_nxt = (rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        result.valid     = 1'b1;
        result.kind      = mfr_pkg::KIND_DATA;
        result.data_byte = rx_byte;
        sum_nxt          = sum_r + rx_byte;
        pos_nxt          = pos_inc;
        if (pos_inc >= ({1'b0, len_r} + DATA_END_OFS)) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        csum_bad_nxt = (rx_byte != sum_r);
        pos_nxt      = pos_inc;
        phase_nxt    = PH_END;
      end
      PH_END: begin
        result.valid        = 1'b1;
        result.kind         = mfr_pkg::KIND_END;
        result.status       = addr_bad_r ? mfr_pkg::ST_ADDR
                            : (csum_bad_r ? mfr_pkg::ST_CSUM : mfr_pkg::ST_OK);
        result.control_code = ctrl_r;
        result.data_length  = len_r;
        pos_nxt             = 9'd0;
        phase_nxt           = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    result.valid = result.valid & byte_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      pos_r      <= 9'd0;
      sum_r      <= 8'd0;
      addr_bad_r <= 1'b0;
      csum_bad_r <= 1'b0;
      ctrl_r     <= 8'd0;
      len_r      <= 8'd0;
    end else if (byte_en) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      addr_bad_r <= addr_bad_nxt;
      csum_bad_r <= csum_bad_nxt;
      ctrl_r     <= ctrl_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule

@@ hw/rtl/meter_frame_receiver.sv @@
// A word that yields a result shows it on the output in the cycle after acceptance.
// Throughput: one input word per cycle while the input is not stalled, set by the frame parser.
// The input stalls only while a result waits in the output register and out_tready is low.
// Reset (rst_n low at a clock edge) returns the parser to hunting for a start byte,
// clears the meter address and empties the output register.
module meter_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data,  // meter_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // data_byte, status, control_code, data_length, zero fill
  output logic        out_tuser     // kind
);

  logic [mfr_pkg::ADDR_W-1:0] meter_address_r;
  logic                       in_accept;
  mfr_pkg::result_t           result;
  logic                       out_valid_r;
  mfr_pkg::kind_t             out_kind_r;
  logic [25:0]                out_data_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meter_address_r <= '0;
    end else if (cfg_wr_en) begin
      meter_address_r <= cfg_wr_data;
    end
  end

  mfr_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_en       (in_accept),
    .rx_byte       (in_tdata),
    .meter_address (meter_address_r),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_kind_r <= result.kind;
      out_data_r <= {result.data_length, result.control_code, result.status, result.data_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};
  assign out_tuser  = out_kind_r;

endmodule

@@ bench/meter_frame_receiver_tb.sv @@
module meter_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mfr_pkg::kind_t   kind;
    logic [7:0]       data_byte;
    mfr_pkg::status_t status;
    logic [7:0]       control_code;
    logic [7:0]       data_length;
  } meter_word_t;

  typedef enum logic [2:0] {
    P_HUNT,
    P_ADDR,
    P_SYNC,
    P_CTRL,
    P_LEN,
    P_DATA,
    P_CSUM,
    P_END
  } parse_phase_t;

  localparam int PHASE_BYTES = 225;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [47:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  meter_frame_receiver i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #5ns clk = ~clk;

  // Shadow copy of the parser and of the meter address.
  logic [47:0]  meter_addr = '0;
  parse_phase_t rx_phase   = P_HUNT;
  logic [8:0]   rx_pos     = '0;
  logic [7:0]   rx_sum     = '0;
  logic [7:0]   held_ctrl  = '0;
  logic [7:0]   held_len   = '0;
  logic         addr_bad   = 1'b0;
  logic         csum_bad   = 1'b0;

  meter_word_t expected_words[$];
  logic [7:0]  rx_pending[$];
  meter_word_t seen_word;
  meter_word_t want_word;

  int   mismatches    = 0;
  int   quiet_cycles  = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   hold_asks     = 0;
  int   hold_seen     = 0;
  int   hold_count    = 0;
  int   queued_bytes  = 0;
  logic in_taken      = 1'b0;

  function automatic void parse_rx_byte(input logic [7:0] b);
    mfr_pkg::status_t st;
    case (rx_phase)
      P_HUNT: begin
        if (b == mfr_pkg::START_BYTE) begin
          rx_sum   = b;
          rx_pos   = 9'd1;
          addr_bad = 1'b0;
          csum_bad = 1'b0;
          rx_phase = P_ADDR;
        end
      end
      P_ADDR: begin
        if (b != meter_addr[8 * (int'(rx_pos) - 1) +: 8]) addr_bad = 1'b1;
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 9'd1;
        if (rx_pos >= 9'd7) rx_phase = P_SYNC;
      end
      P_SYNC: begin
        if (b == mfr_pkg::START_BYTE) begin
          rx_sum   = rx_sum + b;
          rx_pos   = 9'd8;
          rx_phase = P_CTRL;
        end else begin
          expected_words.push_back('{kind: mfr_pkg::KIND_END, data_byte: 8'h00,
                                     status: mfr_pkg::ST_SYNC,
                                     control_code: 8'h00, data_length: 8'h00});
          rx_pos   = '0;
          rx_phase = P_HUNT;
        end
      end
      P_CTRL: begin
        held_ctrl = b;
        rx_sum    = rx_sum + b;
        rx_pos    = 9'd9;
        rx_phase  = P_LEN;
      end
      P_LEN: begin
        held_len = b;
        rx_sum   = rx_sum + b;
        rx_pos   = 9'd10;
        rx_phase = (b == 8'h00) ? P_CSUM : P_DATA;
      end
      P_DATA: begin
        expected_words.push_back('{kind: mfr_pkg::KIND_DATA, data_byte: b,
                                   status: mfr_pkg::ST_OK,
                                   control_code: 8'h00, data_length: 8'h00});
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 9'd1;
        if (rx_pos >= {1'b0, held_len} + 9'(mfr_pkg::FRAME_OVERHEAD - 2))
          rx_phase = P_CSUM;
      end
      P_CSUM: begin
        csum_bad = (b != rx_sum);
        rx_pos   = rx_pos + 9'd1;
        rx_phase = P_END;
      end
      default: begin
        st = addr_bad ? mfr_pkg::ST_ADDR : (csum_bad ? mfr_pkg::ST_CSUM : mfr_pkg::ST_OK);
        expected_words.push_back('{kind: mfr_pkg::KIND_END, data_byte: 8'h00, status: st,
                                   control_code: held_ctrl, data_length: held_len});
        rx_pos   = '0;
        rx_phase = P_HUNT;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_wr_en) meter_addr = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        parse_rx_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        seen_word = '{kind: mfr_pkg::kind_t'(out_tuser), data_byte: out_tdata[7:0],
                      status: mfr_pkg::status_t'(out_tdata[9:8]),
                      control_code: out_tdata[17:10],
                      data_length: out_tdata[25:18]};
        if (expected_words.size() == 0) begin
          $error("result word with none expected: kind %0d, data_byte %0h, status %0d",
                 seen_word.kind, seen_word.data_byte, seen_word.status);
          mismatches++;
        end else begin
          want_word = expected_words.pop_front();
          if (seen_word.kind != want_word.kind) begin
            $error("kind: expected %0d, got %0d", want_word.kind, seen_word.kind);
            mismatches++;
          end
          if (seen_word.data_byte != want_word.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want_word.data_byte, seen_word.data_byte);
            mismatches++;
          end
          if (seen_word.status != want_word.status) begin
            $error("status: expected %0d, got %0d", want_word.status, seen_word.status);
            mismatches++;
          end
          if (seen_word.control_code != want_word.control_code) begin
            $error("control_code: expected %0h, got %0h",
                   want_word.control_code, seen_word.control_code);
            mismatches++;
          end
          if (seen_word.data_length != want_word.data_length) begin
            $error("data_length: expected %0h, got %0h",
                   want_word.data_length, seen_word.data_length);
            mismatches++;
          end
        end
      end
      if (in_taken || (out_tvalid && out_tready) || cfg_wr_en) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_pending.pop_front();
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen  = hold_asks;
      hold_count = HOLD_CYCLES;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_frame(input int len, input bit addr_ok, input bit sync_ok,
                            input bit csum_ok);
    logic [7:0] sum;
    logic [7:0] b;
    int         bad_idx;
    bad_idx = $urandom_range(5);
    sum = mfr_pkg::START_BYTE;
    rx_pending.push_back(mfr_pkg::START_BYTE);
    for (int i = 0; i < 6; i++) begin
      b = meter_addr[8 * i +: 8];
      if (!addr_ok && i == bad_idx) b = b ^ 8'($urandom_range(1, 255));
      sum = sum + b;
      rx_pending.push_back(b);
    end
    queued_bytes += 8;
    if (!sync_ok) begin
      do b = 8'($urandom); while (b == mfr_pkg::START_BYTE);
      rx_pending.push_back(b);
      return;
    end
    rx_pending.push_back(mfr_pkg::START_BYTE);
    sum = sum + mfr_pkg::START_BYTE;
    b = 8'($urandom);
    rx_pending.push_back(b);
    sum = sum + b;
    rx_pending.push_back(8'(len));
    sum = sum + 8'(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      rx_pending.push_back(b);
      sum = sum + b;
    end
    if (!csum_ok) sum = sum ^ 8'($urandom_range(1, 255));
    rx_pending.push_back(sum);
    rx_pending.push_back(8'($urandom));
    queued_bytes += len + 4;
  endtask

  task automatic write_meter_address(input logic [47:0] addr);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_tvalid || expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          pick;
    logic [47:0] addr;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Address is zero after reset: a good empty frame, dropped bytes, a bad second start.
    push_frame(0, 1'b1, 1'b1, 1'b1);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hff);
    push_frame(0, 1'b1, 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      case (p)
        0: addr = meter_addr;
        1: addr = 48'hffff_ffff_ffff;
        3: addr = '0;
        default: addr = {16'($urandom), 32'($urandom)};
      endcase
      if (p != 0) write_meter_address(addr);
      queued_bytes = 0;
      if (p == 0) push_frame(255, 1'b1, 1'b1, 1'b1);
      while (queued_bytes < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          rx_pending.push_back(8'($urandom));
          queued_bytes++;
        end else if (pick < 20) begin
          push_frame($urandom_range(0, 3), $urandom_range(1) == 1, 1'b0, 1'b1);
        end else begin
          push_frame(($urandom_range(24) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12),
                     $urandom_range(3) != 0, 1'b1, $urandom_range(3) != 0);
        end
      end
      if (p == 4) hold_asks++;
      wait_drained();
    end

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
